@@ hw/rtl/threshold_trading_reward_unit_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef THRESHOLD_TRADING_REWARD_UNIT_DEFINES_SVH
`define THRESHOLD_TRADING_REWARD_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is active.
`define TTRU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define TTRU_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/trr_pkg.sv @@
`timescale 1ns / 1ps

package trr_pkg;

  localparam int PRICE_W    = 16;
  localparam int PPR_W      = 9;
  localparam int THR_W      = 17;
  localparam int MAXI_W     = 8;
  localparam int HELD_W     = 8;
  localparam int GAIN_W     = 25;
  localparam int ROUND_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - GAIN_W - ROUND_W - HELD_W;

  localparam int MAX_ROUND_LENGTH_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_PRICES_PER_ROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITEMS        = 2'd2;

  localparam logic [PPR_W-1:0]  PPR_RST  = 9'd1;
  localparam logic [THR_W-1:0]  THR_RST  = 17'd32768;
  localparam logic [MAXI_W-1:0] MAXI_RST = 8'd1;

  localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

  typedef struct packed {
    logic [PPR_W-1:0]  prices_per_round;
    logic [THR_W-1:0]  threshold_level;
    logic [MAXI_W-1:0] max_items;
  } cfg_t;

  // Packed so that round_gain sits in the lowest bits.
  typedef struct packed {
    logic [HELD_W-1:0]         held_after;
    logic [ROUND_W-1:0]        round_number;
    logic signed [GAIN_W-1:0]  round_gain;
  } result_t;

endpackage

@@ hw/rtl/trr_cfg_regs.sv @@
`timescale 1ns / 1ps

module trr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [trr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output trr_pkg::cfg_t                   cfg
);

  trr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prices_per_round <= trr_pkg::PPR_RST;
      cfg_r.threshold_level  <= trr_pkg::THR_RST;
      cfg_r.max_items        <= trr_pkg::MAXI_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        trr_pkg::CFG_PRICES_PER_ROUND: begin
          cfg_r.prices_per_round <= cfg_data[trr_pkg::PPR_W-1:0];
        end
        trr_pkg::CFG_THRESHOLD_LEVEL: begin
          cfg_r.threshold_level <= cfg_data[trr_pkg::THR_W-1:0];
        end
        trr_pkg::CFG_MAX_ITEMS: begin
          cfg_r.max_items <= cfg_data[trr_pkg::MAXI_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/trr_trade_core.sv @@
`timescale 1ns / 1ps

module trr_trade_core #(
  parameter int MAX_ROUND_LENGTH = trr_pkg::MAX_ROUND_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trr_pkg::cfg_t                 cfg,
  input  logic [trr_pkg::PRICE_W-1:0]   price,
  input  logic                          commit,
  output logic                          last,
  output trr_pkg::result_t              result
);

  localparam int POS_W = (MAX_ROUND_LENGTH > 1) ? $clog2(MAX_ROUND_LENGTH) : 1;
  localparam int LEN_W = $clog2(MAX_ROUND_LENGTH + 1);
  localparam int CMP_W = ((LEN_W > trr_pkg::PPR_W) ? LEN_W : trr_pkg::PPR_W) + 1;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_ROUND_LENGTH);
  localparam int GW = trr_pkg::GAIN_W;

  logic [trr_pkg::HELD_W-1:0]  held_r,  held_nxt;
  logic [POS_W-1:0]            pos_r,   pos_nxt;
  logic signed [GW-1:0]        gain_r,  gain_nxt;
  logic [trr_pkg::ROUND_W-1:0] round_r, round_nxt;

  logic [CMP_W-1:0]     ppr_ext;
  logic [CMP_W-1:0]     len;
  logic [CMP_W-1:0]     pos_ext;
  logic signed [CMP_W:0] rem;
  logic signed [CMP_W:0] rem_m1;
  logic signed [CMP_W:0] held_s;
  logic                 price_ge_thr;
  logic                 do_sell;
  logic                 do_buy;
  logic signed [GW:0]   operand;
  logic signed [GW:0]   sum;
  logic signed [GW-1:0] gain_trade;
  logic [trr_pkg::HELD_W-1:0] held_trade;

  always_comb begin
    ppr_ext = CMP_W'(cfg.prices_per_round);
    if (ppr_ext == '0) begin
      len = CMP_W'(1);
    end else if (ppr_ext > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = ppr_ext;
    end
  end

  assign pos_ext      = CMP_W'(pos_r);
  assign rem          = signed'({1'b0, len}) - signed'({1'b0, pos_ext});
  assign rem_m1       = rem - signed'((CMP_W+1)'(1));
  assign held_s       = signed'((CMP_W+1)'(held_r));
  assign price_ge_thr = {1'b0, price} >= cfg.threshold_level;

  assign do_sell = (held_r != '0) && ((rem == held_s) || price_ge_thr);
  assign do_buy  = !do_sell && (rem_m1 != held_s) && !price_ge_thr &&
                   (held_r < cfg.max_items);

  assign operand = do_sell ? signed'((GW+1)'(price)) : -signed'((GW+1)'(price));
  assign sum     = signed'({gain_r[GW-1], gain_r}) + operand;

  always_comb begin
    gain_trade = gain_r;
    held_trade = held_r;
    if (do_sell || do_buy) begin
      if (sum > signed'({trr_pkg::GAIN_MAX[GW-1], trr_pkg::GAIN_MAX})) begin
        gain_trade = trr_pkg::GAIN_MAX;
      end else if (sum < signed'({trr_pkg::GAIN_MIN[GW-1], trr_pkg::GAIN_MIN})) begin
        gain_trade = trr_pkg::GAIN_MIN;
      end else begin
        gain_trade = sum[GW-1:0];
      end
    end
    if (do_sell) begin
      held_trade = held_r - trr_pkg::HELD_W'(1);
    end else if (do_buy) begin
      held_trade = held_r + trr_pkg::HELD_W'(1);
    end
  end

  assign last = (pos_ext + CMP_W'(1)) >= len;

  always_comb begin
    held_nxt  = held_trade;
    gain_nxt  = gain_trade;
    pos_nxt   = pos_r + POS_W'(1);
    round_nxt = round_r;
    if (last) begin
      gain_nxt  = '0;
      pos_nxt   = '0;
      round_nxt = round_r + trr_pkg::ROUND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      pos_r   <= '0;
      gain_r  <= '0;
      round_r <= '0;
    end else if (commit) begin
      held_r  <= held_nxt;
      pos_r   <= pos_nxt;
      gain_r  <= gain_nxt;
      round_r <= round_nxt;
    end
  end

  assign result.round_gain   = gain_trade;
  assign result.round_number = round_r;
  assign result.held_after   = held_trade;

endmodule

@@ hw/rtl/threshold_trading_reward_unit.sv @@
`timescale 1ns / 1ps

// Threshold trading reward unit.
// Input channel (in_*): one Q0.16 price per beat. Result channel (out_*):
// one beat per finished round carrying the round's gain, the round index
// and the inventory held after the round. Configuration channel (cfg_*):
// register writes, always ready, to be written only while the block is idle.
// A price accepted at a clock edge is registered in the input register and
// evaluated there; a round-ending price commits once the output register is
// free, and its result is registered there, which raises out_tvalid.
// Throughput: one price per cycle while no result waits on a stalled receiver;
// inventory, position and gain update combinationally, so prices follow directly.
// When the receiver stalls, prices that do not end a round keep flowing;
// a price that ends a round waits in the input register until the output
// register frees up, and in_tready drops for that time.
// Reset clears inventory, position, gain and round index, empties both
// registers and restores the configuration registers to their defaults.

module threshold_trading_reward_unit #(
  parameter int MAX_ROUND_LENGTH = trr_pkg::MAX_ROUND_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // price [15:0]
  input  logic [trr_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // round_gain [24:0], round_number [56:25], held_after [64:57], zeros above
  output logic [trr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [trr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  trr_pkg::cfg_t    cfg;
  trr_pkg::result_t result;
  trr_pkg::result_t out_res_r;

  logic                        in_valid_r;
  logic [trr_pkg::PRICE_W-1:0] in_price_r;
  logic                        out_valid_r;
  logic                        last;
  logic                        out_free;
  logic                        commit;

  assign cfg_ready = 1'b1;

  trr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trr_trade_core #(
    .MAX_ROUND_LENGTH (MAX_ROUND_LENGTH)
  ) u_trade_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .price  (in_price_r),
    .commit (commit),
    .last   (last),
    .result (result)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign commit    = in_valid_r && (!last || out_free);
  assign in_tready = !in_valid_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (commit && last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_price_r <= in_tdata[trr_pkg::PRICE_W-1:0];
    end
    if (commit && last) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{trr_pkg::OUT_PAD_W{1'b0}}, out_res_r};

endmodule

@@ hw/rtl/trr_checker.sv @@
`timescale 1ns / 1ps
`include "threshold_trading_reward_unit_defines.svh"

module trr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [trr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result beat keeps its payload.
  `TTRU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")

  // The input side only backs up while a result waits on a stalled receiver.
  `TTRU_ASSERT(a_in_backpressure, clk, rst_n, !in_tready |-> out_tvalid && !out_tready, "input stalled without a waiting result")

  // Reset leaves no result pending and the input open.
  `TTRU_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_tvalid && in_tready, "block not empty after reset")

  // The padding above held_after stays zero.
  `TTRU_ASSERT(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[trr_pkg::OUT_TDATA_W-1 -: trr_pkg::OUT_PAD_W] == '0, "result padding not zero")

endmodule

bind threshold_trading_reward_unit trr_checker u_trr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/trade_checker.sv @@
`timescale 1ns / 1ps

module trade_checker #(
  parameter int MAX_LEN = trr_pkg::MAX_ROUND_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [trr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [trr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [trr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fails,
  output int                               pending
);
  import trr_pkg::*;

  cfg_t               settings;
  logic [HELD_W-1:0]  held_units;
  logic [7:0]         slot;
  int                 gain_sum;
  logic [ROUND_W-1:0] round_count;
  result_t            expected_rounds[$];
  result_t            got;
  result_t            want;

  initial begin
    fails = 0;
    pending = 0;
  end

  task automatic flag_error(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fails++;
  endtask

  function automatic int clamp_gain(input int v);
    if (v > int'(GAIN_MAX)) return int'(GAIN_MAX);
    if (v < int'(GAIN_MIN)) return int'(GAIN_MIN);
    return v;
  endfunction

  task automatic trade_price(input logic [PRICE_W-1:0] price);
    int      span;
    int      left;
    int      p;
    int      t;
    result_t r;
    span = int'(settings.prices_per_round);
    if (span < 1) span = 1;
    if (span > MAX_LEN) span = MAX_LEN;
    left = span - int'(slot);
    p = int'(price);
    t = int'(settings.threshold_level);
    if (held_units != 0 && (left == int'(held_units) || p >= t)) begin
      gain_sum = clamp_gain(gain_sum + p);
      held_units = held_units - 1'b1;
    end else if (left - 1 != int'(held_units) && p < t &&
                 held_units < settings.max_items) begin
      gain_sum = clamp_gain(gain_sum - p);
      held_units = held_units + 1'b1;
    end
    if (int'(slot) + 1 >= span) begin
      r.round_gain = gain_sum[GAIN_W-1:0];
      r.round_number = round_count;
      r.held_after = held_units;
      expected_rounds.push_back(r);
      gain_sum = 0;
      slot = '0;
      round_count = round_count + 1'b1;
    end else begin
      slot = slot + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.prices_per_round = PPR_RST;
      settings.threshold_level = THR_RST;
      settings.max_items = MAXI_RST;
      held_units = '0;
      slot = '0;
      gain_sum = 0;
      round_count = '0;
      expected_rounds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRICES_PER_ROUND: settings.prices_per_round = cfg_data[PPR_W-1:0];
          CFG_THRESHOLD_LEVEL:  settings.threshold_level = cfg_data[THR_W-1:0];
          CFG_MAX_ITEMS:        settings.max_items = cfg_data[MAXI_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_rounds.size() == 0) begin
          flag_error("round result beat with no round expected");
        end else begin
          want = expected_rounds.pop_front();
          got = out_tdata[OUT_TDATA_W-OUT_PAD_W-1:0];
          if (got.round_gain !== want.round_gain)
            flag_error($sformatf("round %0d gain %0d, expected %0d",
                                 want.round_number, got.round_gain, want.round_gain));
          if (got.round_number !== want.round_number)
            flag_error($sformatf("round number %0d, expected %0d",
                                 got.round_number, want.round_number));
          if (got.held_after !== want.held_after)
            flag_error($sformatf("round %0d held %0d, expected %0d",
                                 want.round_number, got.held_after, want.held_after));
          if (out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
            flag_error($sformatf("round %0d padding bits %b not zero", want.round_number,
                                 out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]));
        end
      end
      if (in_tvalid && in_tready) trade_price(in_tdata[PRICE_W-1:0]);
    end
    pending = expected_rounds.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import trr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fails;
  int pending;
  int sent;
  int rounds_out;
  int stall_cycles;
  int thr_now;
  bit steady;

  threshold_trading_reward_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  trade_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) rounds_out <= rounds_out + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_price(input logic [PRICE_W-1:0] p);
    while (!steady && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD_LEVEL) thr_now = int'(val);
  endtask

  initial begin
    int r;
    int n;
    int p;
    int len_pick;
    int thr_pick;
    int cap_pick;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    rounds_out = 0;
    stall_cycles = 0;
    sent = 0;
    steady = 1'b0;
    thr_now = int'(THR_RST);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_price(16'd0);
    send_price(16'd32767);
    send_price(16'd32768);
    send_price(16'hFFFF);

    write_reg(CFG_PRICES_PER_ROUND, 17'd0);
    write_reg(CFG_THRESHOLD_LEVEL, 17'd65536);
    write_reg(CFG_MAX_ITEMS, 17'd0);
    send_price(16'd0);
    send_price(16'hFFFF);

    write_reg(CFG_PRICES_PER_ROUND, 17'd5);
    write_reg(CFG_THRESHOLD_LEVEL, 17'd40000);
    write_reg(CFG_MAX_ITEMS, 17'd255);
    send_price(16'd0);
    send_price(16'd100);
    send_price(16'd39999);
    send_price(16'd40000);
    send_price(16'hFFFF);
    send_price(16'd1);
    send_price(16'd2);

    // Shrinking the round while past its new end closes it on the next price.
    write_reg(CFG_UNUSED_IDX, 17'h1ABCD);
    write_reg(CFG_PRICES_PER_ROUND, 17'd2);
    send_price(16'd50);
    send_price(16'd60);
    send_price(16'd70);

    write_reg(CFG_PRICES_PER_ROUND, 17'd511);
    write_reg(CFG_THRESHOLD_LEVEL, 17'd131071);
    write_reg(CFG_MAX_ITEMS, 17'h1FE03);
    send_price(16'd0);
    send_price(16'hFFFF);
    send_price(16'd7);

    write_reg(CFG_PRICES_PER_ROUND, 17'h1FE03);
    write_reg(CFG_THRESHOLD_LEVEL, 17'd65536);
    send_price(16'hFFFF);
    send_price(16'd0);
    send_price(16'h8000);

    while (sent < TOTAL_ITEMS || rounds_out < 40) begin
      r = $urandom_range(99);
      if (r < 70) len_pick = $urandom_range(8, 1);
      else if (r < 84) len_pick = $urandom_range(40, 9);
      else if (r < 90) len_pick = 256;
      else if (r < 93) len_pick = 0;
      else if (r < 96) len_pick = $urandom_range(511, 257);
      else len_pick = $urandom_range(255, 41);
      r = $urandom_range(99);
      if (r < 30) thr_pick = $urandom_range(65536);
      else if (r < 45) thr_pick = 32768;
      else if (r < 55) thr_pick = 0;
      else if (r < 65) thr_pick = 65536;
      else if (r < 75) thr_pick = $urandom_range(131071, 65537);
      else thr_pick = $urandom_range(131071);
      r = $urandom_range(99);
      if (r < 40) cap_pick = $urandom_range(4, 1);
      else if (r < 55) cap_pick = 0;
      else if (r < 70) cap_pick = 255;
      else cap_pick = $urandom_range(255);

      write_reg(CFG_PRICES_PER_ROUND, (17'($urandom) & ~17'h1FF) | 17'(len_pick));
      write_reg(CFG_THRESHOLD_LEVEL, 17'(thr_pick));
      write_reg(CFG_MAX_ITEMS, (17'($urandom) & ~17'hFF) | 17'(cap_pick));

      if (len_pick >= 256 && $urandom_range(1) == 0) n = $urandom_range(300, 256);
      else n = $urandom_range(40, 8);
      repeat (n) begin
        steady = (sent >= 250 && sent < 350);
        r = $urandom_range(99);
        if (r < 15) begin
          p = thr_now + int'($urandom_range(2)) - 1;
          if (p < 0) p = 0;
          if (p > 65535) p = 65535;
        end else if (r < 22) begin
          p = 0;
        end else if (r < 29) begin
          p = 65535;
        end else begin
          p = $urandom_range(65535);
        end
        send_price(16'(p));
      end
    end

    in_tvalid <= 1'b0;
    steady = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/trr_pkg.sv
hw/rtl/trr_cfg_regs.sv
hw/rtl/trr_trade_core.sv
hw/rtl/threshold_trading_reward_unit.sv
hw/rtl/trr_checker.sv
bench/trade_checker.sv
bench/tb.sv
